/* rtl/anlf_pkg.sv */
// ----------------------------------------------------------------------------
// anlf_pkg: shared types and constants of the nibble link framer
// Result kinds, the per-item result plan and the queue geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package anlf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
  localparam logic [1:0] CFG_END_CHAR  = 2'd1;
  localparam logic [1:0] CFG_MODE      = 2'd2;

  // Line constants.
  localparam logic [7:0] HEADER_MARK = 8'h80;
  localparam logic [3:0] NIBBLE_TAG  = 4'h3;
  localparam logic [7:0] ESC_CHAR    = 8'h1B;

  // Result queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_RXBYTE = 2'd1,
    KIND_END   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } res_t;

  // Up to four results that one input item causes, in output order.
  typedef struct packed {
    res_t [3:0] res;
    logic [1:0] last_idx;
  } plan_t;

endpackage

`default_nettype wire

/* rtl/anlf_front.sv */
// ----------------------------------------------------------------------------
// anlf_front: item classification and framing state
// Accepts one item a cycle unless stalled, updates the link state and builds its result plan.
// ----------------------------------------------------------------------------
`default_nettype none

module anlf_front import anlf_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       item_valid_i,
  input  wire logic       operation_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       first_item_i,
  input  wire logic       last_item_i,
  input  wire logic [8:0] frame_length_i,
  input  wire logic       queue_full_i,
  output logic            item_ready_o,
  output logic            push_o,
  output plan_t           plan_o
);

  logic [6:0]  node_q;
  logic [7:0]  endc_q;
  logic        mode_q;
  logic        esc_q, esc_d;
  logic        odd_q, odd_d;
  logic [3:0]  held_q, held_d;
  logic        txd_q, txd_d;
  logic        rxd_q, rxd_d;

  logic        accept;
  logic        binary;
  logic [10:0] packet;
  logic [2:0]  n;
  logic        aborted;

  // A register write takes the cycle, so no item is taken alongside it.
  assign item_ready_o = ~queue_full_i & ~cfg_valid_i;
  assign accept       = item_valid_i & item_ready_o;
  assign binary       = mode_q & ~esc_q;
  assign packet       = binary ? (11'd2 + {1'b0, frame_length_i, 1'b0})
                               : (11'd2 + {2'b00, frame_length_i});

  always_comb begin
    plan_o  = '0;
    n       = 3'd0;
    aborted = 1'b0;
    esc_d   = esc_q;
    odd_d   = odd_q;
    held_d  = held_q;
    txd_d   = txd_q;
    rxd_d   = rxd_q;
    if (!operation_i) begin
      if (first_item_i) begin
        txd_d = (frame_length_i == 9'd0) || (32'(packet) > 32'(BUFFER_BYTES));
        if (!txd_d) begin
          plan_o.res[n[1:0]] = '{kind: KIND_LINE, data: HEADER_MARK | {1'b0, node_q}};
          n = n + 3'd1;
        end
      end
      if (!txd_d) begin
        if (binary) begin
          plan_o.res[n[1:0]] = '{kind: KIND_LINE, data: {NIBBLE_TAG, data_byte_i[7:4]}};
          n = n + 3'd1;
          plan_o.res[n[1:0]] = '{kind: KIND_LINE, data: {NIBBLE_TAG, data_byte_i[3:0]}};
          n = n + 3'd1;
        end else begin
          plan_o.res[n[1:0]] = '{kind: KIND_LINE, data: data_byte_i};
          n = n + 3'd1;
        end
        if (last_item_i) begin
          plan_o.res[n[1:0]] = '{kind: KIND_LINE, data: endc_q};
          n = n + 3'd1;
        end
      end
    end else begin
      if (first_item_i) begin
        odd_d  = 1'b0;
        held_d = 4'd0;
        rxd_d  = 1'b0;
      end
      if (!rxd_d) begin
        if (binary) begin
          if (data_byte_i[5:4] == 2'b11) begin
            if (!odd_d) begin
              held_d = data_byte_i[3:0];
            end else begin
              plan_o.res[n[1:0]] = '{kind: KIND_RXBYTE, data: {held_d, data_byte_i[3:0]}};
              n = n + 3'd1;
            end
          end else if (data_byte_i == ESC_CHAR) begin
            esc_d   = 1'b1;
            rxd_d   = 1'b1;
            aborted = 1'b1;
            plan_o.res[n[1:0]] = '{kind: KIND_ABORT, data: 8'd0};
            n = n + 3'd1;
          end
        end else begin
          plan_o.res[n[1:0]] = '{kind: KIND_RXBYTE, data: data_byte_i};
          n = n + 3'd1;
        end
        if (!aborted) begin
          odd_d = ~odd_d;
          if (last_item_i) begin
            plan_o.res[n[1:0]] = '{kind: KIND_END, data: 8'd0};
            n = n + 3'd1;
          end
        end
      end
    end
    plan_o.last_idx = 2'(n - 3'd1);
  end

  // Items that cause no result never enter the queue.
  assign push_o = accept & (n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= 7'd0;
      endc_q <= 8'd10;
      mode_q <= 1'b0;
      esc_q  <= 1'b0;
      odd_q  <= 1'b0;
      held_q <= 4'd0;
      txd_q  <= 1'b0;
      rxd_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NODE_ADDR: node_q <= cfg_data_i[6:0];
        CFG_END_CHAR:  endc_q <= cfg_data_i;
        CFG_MODE: begin
          mode_q <= cfg_data_i[0];
          esc_q  <= 1'b0;
        end
        default: ;
      endcase
    end else if (accept) begin
      esc_q  <= esc_d;
      odd_q  <= odd_d;
      held_q <= held_d;
      txd_q  <= txd_d;
      rxd_q  <= rxd_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/anlf_queue.sv */
// ----------------------------------------------------------------------------
// anlf_queue: result plan queue
// A small first-in first-out store of result plans between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module anlf_queue import anlf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  plan_t      plan_i,
  input  wire logic  pop_i,
  output logic       full_o,
  output logic       nonempty_o,
  output plan_t      head_o
);

  plan_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o     = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("plan pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !nonempty_o)) else $error("plan popped from an empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH)) else $error("queue fill count out of range");

endmodule

`default_nettype wire

/* rtl/anlf_back.sv */
// ----------------------------------------------------------------------------
// anlf_back: result sequencer
// Walks the head plan one result a beat into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module anlf_back import anlf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  plan_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  res_t       res_q;
  logic       last_q;
  logic       load;
  logic       at_last;

  assign load    = head_valid_i & (~valid_q | out_ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load & at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      last_q <= at_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = res_q.kind;
  assign out_byte_o  = res_q.data;
  assign out_last_o  = last_q;

  a_idx_in_plan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.last_idx) else $error("result index past plan end");
  a_idx_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0) else $error("result index not rewound after pop");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q)) else $error("popped plan not closed by a last beat");

endmodule

`default_nettype wire

/* rtl/addressed_nibble_link_framer_core.sv */
// ----------------------------------------------------------------------------
// addressed_nibble_link_framer_core: framed serial link codec, top level
// Front classifies items and plans results, a plan queue decouples it from
// the back, which sends one result beat per cycle while the output is ready.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake              Beat contents
// s_axis    in   tvalid/tready          one transmit or received line byte
// m_axis    out  tvalid/tready          one result (line byte, rx byte, end, abort)
// cfg       in   cfg_valid_i/ready_o    register index and write data
//
// An accepted item's plan is queued before its results load the output register.
// The output port sends one result per cycle while m_axis_tready is high.
// A binary transmit byte is two beats; header and end character add one each.
// Up to four queued plans let input beats be taken while results drain.
// Reset clears all link state; end character resets to 10.
// Input stalls when the plan queue is full or while a register write is
// presented; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_nibble_link_framer_core import anlf_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // data_byte[7:0], frame_length[16:8], zero
  input  wire logic [1:0]  s_axis_tuser,  // operation[0], first_item[1]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
  output logic [1:0]       m_axis_tuser,  // out_kind[1:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  logic  queue_full;
  logic  push;
  logic  pop;
  logic  head_valid;
  plan_t plan;
  plan_t head;

  assign cfg_ready_o = 1'b1;

  anlf_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (s_axis_tvalid),
    .operation_i   (s_axis_tuser[0]),
    .data_byte_i   (s_axis_tdata[7:0]),
    .first_item_i  (s_axis_tuser[1]),
    .last_item_i   (s_axis_tlast),
    .frame_length_i(s_axis_tdata[16:8]),
    .queue_full_i  (queue_full),
    .item_ready_o  (s_axis_tready),
    .push_o        (push),
    .plan_o        (plan)
  );

  anlf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .plan_i    (plan),
    .pop_i     (pop),
    .full_o    (queue_full),
    .nonempty_o(head_valid),
    .head_o    (head)
  );

  anlf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
